@@ src/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg: barometric pressure compensation shared definitions
// Register indexes, calibration constants and the rounding helper used by the
// compensation datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_TEMP    = 3'd0;
  localparam logic [2:0] REG_PRESS_A = 3'd1;
  localparam logic [2:0] REG_PRESS_B = 3'd2;
  localparam logic [2:0] REG_PRESS_C = 3'd3;

  // offset removed from the P1 and P2 calibration numbers
  localparam logic signed [16:0] P_OFFSET = 17'sd16384;

  // conversion of Pa in Q24 to 1/4096 hPa: divide by 25 * 2^14
  localparam logic [43:0] PRESS_HALF     = 44'd204800;
  localparam logic [43:0] PRESS_MAX_SCL  = 44'd209715200;  // 25 * 2^23
  localparam logic [28:0] DIV25_RECIP    = 29'd343597384;  // ceil(2^33 / 25)
  localparam int          DIV25_SHIFT    = 33;
  localparam logic [22:0] PRESS_MAX      = 23'h7FFFFF;

  localparam logic signed [15:0] TEMP_MAX = 16'sh7FFF;
  localparam logic signed [15:0] TEMP_MIN = -16'sh8000;

  typedef logic signed [71:0] wide_t;

  // round(p / 2^s) to nearest, ties away from zero
  function automatic wide_t rnd_shr(input wide_t p, input int unsigned s);
    logic [71:0] mag;
    logic [71:0] res;
    mag = p[71] ? unsigned'(-p) : unsigned'(p);
    res = (mag + (72'(1) << (s - 1))) >> s;
    return p[71] ? -signed'(res) : signed'(res);
  endfunction

endpackage

`default_nettype wire

@@ src/barometric_pressure_compensation.sv @@
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Cubic calibration polynomial for a barometric sensor: linearized temperature
// in 1/256 degC and pressure in 1/4096 hPa, both rounded and clamped.
// ----------------------------------------------------------------------------
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+-----------------
//  input    | in_raw_pressure, in_raw_temperature           | start, busy
//  result   | out_temperature_out, out_pressure_out,        | out_valid strobe
//           | out_clamped                                   |
//  config   | cfg_index, cfg_data                           | cfg_valid, cfg_ready
//
//  One item enters per clock; each result passes through the 16 register
//  stages of the multiply/round datapath.
//  busy never rises and cfg_ready is always high.
//  Reset (synchronous, active low) clears the valid bits and the coefficients.
//  The result is a one-cycle strobe; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`default_nettype none

module barometric_pressure_compensation (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [23:0]        in_raw_pressure,
  input  wire logic [23:0]        in_raw_temperature,
  output logic                    out_valid,
  output logic signed [15:0]      out_temperature_out,
  output logic [22:0]             out_pressure_out,
  output logic                    out_clamped,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [47:0]        cfg_data
);

  // configuration registers
  logic [39:0] temp_coeffs_r;
  logic [47:0] press_a_r;
  logic [47:0] press_b_r;
  logic [31:0] press_c_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_a_r     <= '0;
      press_b_r     <= '0;
      press_c_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bpc_pkg::REG_TEMP:    temp_coeffs_r <= cfg_data[39:0];
        bpc_pkg::REG_PRESS_A: press_a_r     <= cfg_data;
        bpc_pkg::REG_PRESS_B: press_b_r     <= cfg_data;
        bpc_pkg::REG_PRESS_C: press_c_r     <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // coefficient fields
  logic [15:0]        t1, t2, p5, p6;
  logic signed [7:0]  t3, p3, p4, p7, p8, p10, p11;
  logic signed [15:0] p1, p2, p9;

  assign t1  = temp_coeffs_r[15:0];
  assign t2  = temp_coeffs_r[31:16];
  assign t3  = $signed(temp_coeffs_r[39:32]);
  assign p1  = $signed(press_a_r[15:0]);
  assign p2  = $signed(press_a_r[31:16]);
  assign p3  = $signed(press_a_r[39:32]);
  assign p4  = $signed(press_a_r[47:40]);
  assign p5  = press_b_r[15:0];
  assign p6  = press_b_r[31:16];
  assign p7  = $signed(press_b_r[39:32]);
  assign p8  = $signed(press_b_r[47:40]);
  assign p9  = $signed(press_c_r[15:0]);
  assign p10 = $signed(press_c_r[23:16]);
  assign p11 = $signed(press_c_r[31:24]);

  // valid bits, one per stage
  logic [15:1] vld_r;
  logic        out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[14:1], start && !busy};
      out_valid_r <= vld_r[15];
    end
  end

  assign out_valid = out_valid_r;

  // carried operands
  logic [23:0]        up_r   [1:10];
  logic signed [32:0] w_r    [1:9];
  logic [47:0]        upsq_r [2:9];
  logic signed [36:0] tq_r   [4:8];
  logic [47:0]        tq2_r  [6:8];
  logic signed [15:0] tr_r   [4:15];
  logic               tsat_r [4:15];

  // stage registers
  logic signed [24:0] d_r;
  logic signed [41:0] dt2_r;
  logic [48:0]        dd_r;
  logic signed [60:0] x_r;
  logic [71:0]        sq_r;
  logic [59:0]        t3a_r, t3b_r;
  logic signed [60:0] tq3_r;
  logic signed [53:0] m6_r, m2_r;
  logic signed [56:0] m7_r, m3_r;
  logic signed [68:0] m8_r, m4_r;
  logic signed [45:0] c9_r;
  logic signed [55:0] out1_r [10:12];
  logic signed [55:0] poly_r;
  logic [68:0]        da_r, db_r;
  logic [55:0]        ea_r, eb_r;
  logic               c9neg_r, wneg_r;
  logic [51:0]        oa_r;
  logic [50:0]        ob_r;
  logic               pneg_r;
  logic signed [55:0] data4_r [11:12];
  logic signed [55:0] out2_r;
  logic signed [57:0] pq_r;
  logic [27:0]        m_r;
  logic               neg_r [14:15];
  logic               negsat_r [14:15];
  logic               hisat_r [14:15];
  logic [56:0]        qp_r;
  logic signed [15:0] temp_out_r;
  logic [22:0]        press_out_r;
  logic               clamped_r;

  // stage 1: temperature offset, cubic pressure weight
  logic signed [24:0] d_nxt;
  logic signed [32:0] w_nxt;
  assign d_nxt = $signed({1'b0, in_raw_temperature}) - $signed({1'b0, t1, 8'h00});
  assign w_nxt = $signed({1'b0, in_raw_pressure}) * p11;

  // stage 2: products for the linearized temperature
  logic [24:0] dmag;
  assign dmag = d_r[24] ? unsigned'(-d_r) : unsigned'(d_r);

  // stage 3: exact temperature times 2^48
  logic signed [60:0] x_nxt;
  assign x_nxt = (61'(dt2_r) <<< 18) + ($signed({1'b0, dd_r}) * t3);

  // stage 4: temperature in Q24 and the rounded, clamped output temperature
  bpc_pkg::wide_t tq_full, tr_full;
  logic signed [15:0] tr_nxt;
  logic               tsat_nxt;
  assign tq_full = bpc_pkg::rnd_shr(72'(x_r), 24);
  assign tr_full = bpc_pkg::rnd_shr(72'(x_r), 40);

  always_comb begin
    tsat_nxt = 1'b1;
    if (tr_full > 72'(bpc_pkg::TEMP_MAX)) begin
      tr_nxt = bpc_pkg::TEMP_MAX;
    end else if (tr_full < 72'(bpc_pkg::TEMP_MIN)) begin
      tr_nxt = bpc_pkg::TEMP_MIN;
    end else begin
      tr_nxt   = 16'(tr_full);
      tsat_nxt = 1'b0;
    end
  end

  // stages 5 to 8: square and cube of the temperature
  logic [35:0] tqm4, tqm6;
  assign tqm4 = tq_r[4][36] ? 36'(unsigned'(-tq_r[4])) : 36'(unsigned'(tq_r[4]));
  assign tqm6 = tq_r[6][36] ? 36'(unsigned'(-tq_r[6])) : 36'(unsigned'(tq_r[6]));

  logic [47:0] tq2_nxt;
  assign tq2_nxt = 48'((sq_r + (72'(1) << 23)) >> 24);

  logic [84:0] t3sum;
  logic [59:0] tq3mag;
  assign t3sum  = {1'b0, t3a_r, 24'h000000} + 85'(t3b_r) + (85'(1) << 23);
  assign tq3mag = 60'(t3sum >> 24);

  // stage 9: coefficient products
  logic signed [16:0] p1x, p2x;
  assign p1x = $signed({p1[15], p1}) - bpc_pkg::P_OFFSET;
  assign p2x = $signed({p2[15], p2}) - bpc_pkg::P_OFFSET;

  logic signed [48:0] tq2s8;
  assign tq2s8 = $signed({1'b0, tq2_r[8]});

  // stage 10: offset and sensitivity polynomials, raw pressure partial products
  logic signed [55:0] out1_nxt, poly_nxt;
  assign out1_nxt = $signed({1'b0, p5, 27'h0000000}) + 56'(bpc_pkg::rnd_shr(72'(m6_r), 6))
                  + 56'(bpc_pkg::rnd_shr(72'(m7_r), 8))
                  + 56'(bpc_pkg::rnd_shr(72'(m8_r), 15));
  assign poly_nxt = (56'(p1x) <<< 28) + 56'(bpc_pkg::rnd_shr(72'(m2_r), 5))
                  + 56'(bpc_pkg::rnd_shr(72'(m3_r), 8))
                  + 56'(bpc_pkg::rnd_shr(72'(m4_r), 13));

  logic [44:0] c9mag;
  logic [31:0] wmag;
  assign c9mag = c9_r[45] ? 45'(unsigned'(-c9_r)) : 45'(unsigned'(c9_r));
  assign wmag  = w_r[9][32] ? 32'(unsigned'(-w_r[9])) : 32'(unsigned'(w_r[9]));

  // stage 11: quadratic and cubic pressure terms, sensitivity partial products
  logic [93:0]        dsum;
  logic [80:0]        esum;
  logic [45:0]        d1mag;
  logic [39:0]        e1mag;
  logic signed [55:0] data4_nxt;
  assign dsum  = {1'b0, da_r, 24'h000000} + 94'(db_r) + (94'(1) << 47);
  assign esum  = {1'b0, ea_r, 24'h000000} + 81'(eb_r) + (81'(1) << 40);
  assign d1mag = 46'(dsum >> 48);
  assign e1mag = 40'(esum >> 41);
  assign data4_nxt = (c9neg_r ? -$signed({10'h000, d1mag}) : $signed({10'h000, d1mag}))
                   + (wneg_r ? -$signed({16'h0000, e1mag}) : $signed({16'h0000, e1mag}));

  logic [54:0] polymag;
  assign polymag = poly_r[55] ? 55'(unsigned'(-poly_r)) : 55'(unsigned'(poly_r));

  // stage 12: sensitivity term
  logic [80:0] osum;
  logic [55:0] o2mag;
  assign osum  = {2'b00, oa_r, 27'h0000000} + 81'(ob_r) + (81'(1) << 23);
  assign o2mag = 56'(osum >> 24);

  // stage 14: scale toward 1/4096 hPa and detect clamps
  logic [56:0] pqmag;
  logic [43:0] pscl;
  assign pqmag = pq_r[57] ? 57'(unsigned'(-pq_r)) : 57'(unsigned'(pq_r));
  assign pscl  = 44'((pqmag + 57'(bpc_pkg::PRESS_HALF)) >> 14);

  // stage 16: output selection
  logic [22:0] press_nxt;
  always_comb begin
    if (neg_r[15]) begin
      press_nxt = '0;
    end else if (hisat_r[15]) begin
      press_nxt = bpc_pkg::PRESS_MAX;
    end else begin
      press_nxt = qp_r[bpc_pkg::DIV25_SHIFT +: 23];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // stage 1
    up_r[1] <= in_raw_pressure;
    w_r[1]  <= w_nxt;
    d_r     <= d_nxt;
    for (int k = 2; k <= 10; k++) begin
      up_r[k] <= up_r[k-1];
    end
    for (int k = 2; k <= 9; k++) begin
      w_r[k] <= w_r[k-1];
    end
    // stage 2
    dt2_r     <= d_r * $signed({1'b0, t2});
    dd_r      <= 49'(dmag * dmag);
    upsq_r[2] <= up_r[1] * up_r[1];
    for (int k = 3; k <= 9; k++) begin
      upsq_r[k] <= upsq_r[k-1];
    end
    // stage 3
    x_r <= x_nxt;
    // stage 4
    tq_r[4]   <= 37'(tq_full);
    tr_r[4]   <= tr_nxt;
    tsat_r[4] <= tsat_nxt;
    for (int k = 5; k <= 8; k++) begin
      tq_r[k] <= tq_r[k-1];
    end
    for (int k = 5; k <= 15; k++) begin
      tr_r[k]   <= tr_r[k-1];
      tsat_r[k] <= tsat_r[k-1];
    end
    // stages 5 to 8
    sq_r     <= 72'(tqm4) * 72'(tqm4);
    tq2_r[6] <= tq2_nxt;
    tq2_r[7] <= tq2_r[6];
    tq2_r[8] <= tq2_r[7];
    t3a_r    <= 60'(tq2_r[6][47:24]) * 60'(tqm6);
    t3b_r    <= 60'(tq2_r[6][23:0]) * 60'(tqm6);
    tq3_r    <= tq_r[7][36] ? -$signed({1'b0, tq3mag}) : $signed({1'b0, tq3mag});
    // stage 9
    m6_r <= $signed({1'b0, p6}) * tq_r[8];
    m2_r <= p2x * tq_r[8];
    m7_r <= p7 * tq2s8;
    m3_r <= p3 * tq2s8;
    m8_r <= p8 * tq3_r;
    m4_r <= p4 * tq3_r;
    c9_r <= (46'(p9) <<< 24) + (p10 * tq_r[8]);
    // stage 10
    out1_r[10] <= out1_nxt;
    out1_r[11] <= out1_r[10];
    out1_r[12] <= out1_r[11];
    poly_r     <= poly_nxt;
    da_r       <= 69'(upsq_r[9][47:24]) * 69'(c9mag);
    db_r       <= 69'(upsq_r[9][23:0]) * 69'(c9mag);
    ea_r       <= 56'(upsq_r[9][47:24]) * 56'(wmag);
    eb_r       <= 56'(upsq_r[9][23:0]) * 56'(wmag);
    c9neg_r    <= c9_r[45];
    wneg_r     <= w_r[9][32];
    // stage 11
    data4_r[11] <= data4_nxt;
    data4_r[12] <= data4_r[11];
    oa_r        <= 52'(up_r[10]) * 52'(polymag[54:27]);
    ob_r        <= 51'(up_r[10]) * 51'(polymag[26:0]);
    pneg_r      <= poly_r[55];
    // stage 12
    out2_r <= pneg_r ? -$signed(o2mag) : $signed(o2mag);
    // stage 13
    pq_r <= 58'(out1_r[12]) + 58'(out2_r) + 58'(data4_r[12]);
    // stage 14
    m_r          <= pscl[27:0];
    neg_r[14]    <= pq_r[57];
    negsat_r[14] <= pq_r[57] && (pqmag >= 57'(bpc_pkg::PRESS_HALF));
    hisat_r[14]  <= !pq_r[57] && (pscl >= bpc_pkg::PRESS_MAX_SCL);
    // stage 15
    qp_r         <= 57'(m_r) * 57'(bpc_pkg::DIV25_RECIP);
    neg_r[15]    <= neg_r[14];
    negsat_r[15] <= negsat_r[14];
    hisat_r[15]  <= hisat_r[14];
    // stage 16
    temp_out_r  <= tr_r[15];
    press_out_r <= press_nxt;
    clamped_r   <= tsat_r[15] || negsat_r[15] || hisat_r[15];
  end

  assign out_temperature_out = temp_out_r;
  assign out_pressure_out    = press_out_r;
  assign out_clamped         = clamped_r;

  // every accepted item leaves the pipeline after the full latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##16 out_valid)
    else $error("item did not leave the pipeline on time");

  // a negative pressure can never also be flagged too high
  a_press_flags: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[14] |-> !(neg_r[14] && hisat_r[14]))
    else $error("pressure both negative and above range");

  // a temperature clamp always lands on a range limit
  a_temp_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && tsat_r[4]) |-> (tr_r[4] == bpc_pkg::TEMP_MAX || tr_r[4] == bpc_pkg::TEMP_MIN))
    else $error("temperature clamp off the range limit");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: barometric pressure compensation testbench
// Loads calibration sets through the config channel, drives raw pressure and
// temperature pairs with random gaps, and checks every result strobe against
// a fixed-point prediction of the compensation polynomial.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [47:0] data;
    logic [23:0] rp;
    logic [23:0] rt;
    int unsigned gap;
  } pending_t;

  typedef struct {
    logic signed [15:0] temp;
    logic [22:0]        press;
    logic               clamp;
  } reading_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [23:0]        in_raw_pressure;
  logic [23:0]        in_raw_temperature;
  logic               out_valid;
  logic signed [15:0] out_temperature_out;
  logic [22:0]        out_pressure_out;
  logic               out_clamped;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [47:0]        cfg_data;

  pending_t    sample_q[$];
  reading_t    expected_q[$];
  pending_t    nxt;
  logic [39:0] cal_temp;
  logic [47:0] cal_a;
  logic [47:0] cal_b;
  logic [31:0] cal_c;
  int          gap_left;
  int          quiet;
  int          errors;
  bit          no_idle;
  logic [15:0] cur_t1;

  barometric_pressure_compensation i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_raw_pressure     (in_raw_pressure),
    .in_raw_temperature  (in_raw_temperature),
    .out_valid           (out_valid),
    .out_temperature_out (out_temperature_out),
    .out_pressure_out    (out_pressure_out),
    .out_clamped         (out_clamped),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_raw_pressure = '0;
    in_raw_temperature = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // round(a*b / 2^s), ties away from zero, saturated to 64-bit signed
  function automatic longint mul_round(input longint a, input longint b, input int s);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] prod;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    prod = {64'd0, ua} * {64'd0, ub};
    prod = (prod + (128'd1 << (s - 1))) >> s;
    if (prod > 128'h7FFF_FFFF_FFFF_FFFF) prod = 128'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  // compensated temperature and pressure for one raw pair
  function automatic reading_t compensate(input logic [23:0] rp, input logic [23:0] rt);
    longint   t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    longint   up, d, x, tq, tq2, tq3, offs, sens, span, up2, quad, pq, tr;
    logic [63:0] mag, q;
    reading_t r;
    t1 = cal_temp[15:0];
    t2 = cal_temp[31:16];
    t3 = $signed(cal_temp[39:32]);
    p1 = $signed(cal_a[15:0]);
    p2 = $signed(cal_a[31:16]);
    p3 = $signed(cal_a[39:32]);
    p4 = $signed(cal_a[47:40]);
    p5 = cal_b[15:0];
    p6 = cal_b[31:16];
    p7 = $signed(cal_b[39:32]);
    p8 = $signed(cal_b[47:40]);
    p9 = $signed(cal_c[15:0]);
    p10 = $signed(cal_c[23:16]);
    p11 = $signed(cal_c[31:24]);
    up = rp;
    r.clamp = 1'b0;

    // linearized temperature, exact at 2^48 scale
    d = longint'(rt) - t1 * 256;
    x = d * t2 * 262144 + d * d * t3;
    tq = mul_round(x, 1, 24);
    tq2 = mul_round(tq, tq, 24);
    tq3 = mul_round(tq2, tq, 24);

    // offset, sensitivity and higher-order pressure terms
    offs = p5 * 134217728 + mul_round(p6, tq, 6) + mul_round(p7, tq2, 8)
         + mul_round(p8, tq3, 15);
    sens = (p1 - 16384) * 268435456 + mul_round(p2 - 16384, tq, 5)
         + mul_round(p3, tq2, 8) + mul_round(p4, tq3, 13);
    span = mul_round(up, sens, 24);
    up2 = up * up;
    quad = mul_round(up2, p9 * 16777216 + p10 * tq, 48) + mul_round(up2, up * p11, 41);
    pq = offs + span + quad;

    // Pa in Q24 to 1/4096 hPa with clamp
    if (pq < 0) begin
      mag = -pq;
      q = (mag + 64'd204800) / 64'd409600;
      r.press = '0;
      if (q != 0) r.clamp = 1'b1;
    end else begin
      mag = pq;
      q = (mag + 64'd204800) / 64'd409600;
      if (q > 64'd8388607) begin
        q = 64'd8388607;
        r.clamp = 1'b1;
      end
      r.press = q[22:0];
    end

    tr = mul_round(x, 1, 40);
    if (tr > 32767) begin
      tr = 32767;
      r.clamp = 1'b1;
    end else if (tr < -32768) begin
      tr = -32768;
      r.clamp = 1'b1;
    end
    r.temp = tr[15:0];
    return r;
  endfunction

  task automatic write_cal(input logic [2:0] idx, input logic [47:0] data);
    case (idx)
      bpc_pkg::REG_TEMP:    cal_temp = data[39:0];
      bpc_pkg::REG_PRESS_A: cal_a = data;
      bpc_pkg::REG_PRESS_B: cal_b = data;
      bpc_pkg::REG_PRESS_C: cal_c = data[31:0];
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic add_sample(input logic [23:0] rp, input logic [23:0] rt);
    pending_t p;
    p.is_cfg = 1'b0;
    p.idx = '0;
    p.data = '0;
    p.rp = rp;
    p.rt = rt;
    p.gap = pick_gap();
    sample_q.push_back(p);
  endtask

  task automatic add_write(input logic [2:0] idx, input logic [47:0] data);
    pending_t p;
    p.is_cfg = 1'b1;
    p.idx = idx;
    p.data = data;
    p.rp = '0;
    p.rt = '0;
    p.gap = pick_gap();
    sample_q.push_back(p);
  endtask

  task automatic add_cal_set(input logic [47:0] tw, input logic [47:0] aw,
                             input logic [47:0] bw, input logic [47:0] cw);
    add_write(bpc_pkg::REG_TEMP, tw);
    add_write(bpc_pkg::REG_PRESS_A, aw);
    add_write(bpc_pkg::REG_PRESS_B, bw);
    add_write(bpc_pkg::REG_PRESS_C, cw);
    cur_t1 = tw[15:0];
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // mostly near the calibrated operating point, some anywhere
  task automatic add_random_sample();
    logic [23:0] rt;
    if ($urandom_range(0, 9) < 7)
      rt = 24'({cur_t1, 8'd0}) + 24'($urandom_range(0, 2097152)) - 24'd1048576;
    else
      rt = 24'($urandom);
    add_sample(24'($urandom), rt);
  endtask

  // stimulus
  initial begin
    errors = 0;
    no_idle = 1'b0;
    cur_t1 = '0;

    // all coefficients zero after reset
    add_sample(24'h000000, 24'h000000);
    add_sample(24'hFFFFFF, 24'hFFFFFF);

    // typical calibration, then field extremes and clamp cases
    add_cal_set({8'd0, 8'hF9, 16'd19000, 16'd27000},
                {8'd1, 8'd35, 16'd2700, 16'd2000},
                {8'hF8, 8'd6, 16'd29000, 16'd24000},
                {16'd0, 8'hFD, 8'd4, 16'd1000});
    add_write(3'(bpc_pkg::REG_PRESS_C + 3'd1), 48'hFFFF_FFFF_FFFF);
    add_write(3'(bpc_pkg::REG_PRESS_C + 3'd4), 48'h0);
    add_sample(24'h000000, 24'h000000);
    add_sample(24'hFFFFFF, 24'hFFFFFF);
    add_sample(24'h000000, 24'hFFFFFF);
    add_sample(24'hFFFFFF, 24'h000000);
    add_sample(24'h6B0000, 24'd6912000);
    add_sample(24'h700000, 24'd6912000 + 24'd300000);
    add_sample(24'h400000, 24'd6912000 - 24'd300000);
    add_sample(24'h000001, 24'd6912000);
    add_sample(24'h800000, 24'd6912001);
    add_sample(24'h7FFFFF, 24'd6911999);
    add_sample(24'hAAAAAA, 24'h555555);
    add_sample(24'h555555, 24'hAAAAAA);

    // random calibration sets, extremes among them
    for (int ph = 0; ph < 8; ph++) begin
      no_idle = (ph % 3 == 1);
      case (ph)
        0: add_cal_set(48'hFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                       48'hFFFF_FFFF);
        1: add_cal_set(48'h0, 48'h0, 48'h0, 48'h0);
        2: add_cal_set(48'h80_FFFF_0000, 48'h8080_8000_8000, 48'h8080_FFFF_FFFF,
                       48'h8080_8000);
        default: add_cal_set(rand48(), rand48(), rand48(), rand48());
      endcase
      if ($urandom_range(0, 1))
        add_write(3'(bpc_pkg::REG_PRESS_C + $urandom_range(1, 4)), rand48());
      for (int k = 0; k < 135; k++) add_random_sample();
    end

    // wind down
    wait (sample_q.size() == 0);
    wait (!start && !cfg_valid);
    wait (expected_q.size() == 0);
    repeat (24) @(posedge clk);
    if (expected_q.size() != 0) report_mismatch("results missing at end of run");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // driver: items and register writes, writes only once the pipe has drained
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left = 0;
      quiet = 0;
      cal_temp = '0;
      cal_a = '0;
      cal_b = '0;
      cal_c = '0;
    end else begin
      if (start && !busy) expected_q.push_back(compensate(in_raw_pressure, in_raw_temperature));
      if (cfg_valid && cfg_ready) write_cal(cfg_index, cfg_data);
      if (expected_q.size() == 0 && !(start && !busy)) quiet++;
      else quiet = 0;
      if ((!start || !busy) && (!cfg_valid || cfg_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
          cfg_valid <= 1'b0;
        end else if (sample_q.size() != 0 && (!sample_q[0].is_cfg || quiet >= 20)) begin
          nxt = sample_q.pop_front();
          gap_left = nxt.gap;
          if (nxt.is_cfg) begin
            start <= 1'b0;
            cfg_valid <= 1'b1;
            cfg_index <= nxt.idx;
            cfg_data <= nxt.data;
          end else begin
            cfg_valid <= 1'b0;
            start <= 1'b1;
            in_raw_pressure <= nxt.rp;
            in_raw_temperature <= nxt.rt;
          end
        end else begin
          start <= 1'b0;
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result strobe with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        if (out_temperature_out !== expected_q[0].temp)
          report_mismatch($sformatf("temperature %0d, expected %0d",
                                    out_temperature_out, expected_q[0].temp));
        if (out_pressure_out !== expected_q[0].press)
          report_mismatch($sformatf("pressure %0d, expected %0d",
                                    out_pressure_out, expected_q[0].press));
        if (out_clamped !== expected_q[0].clamp)
          report_mismatch($sformatf("clamp flag %b, expected %b",
                                    out_clamped, expected_q[0].clamp));
        void'(expected_q.pop_front());
      end
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
